>>> hw/rtl/lqrcl_pkg.sv
// Shared types, register codes and microcode table for the LQR state step block.
`default_nettype none

package lqrcl_pkg;

  localparam int STATE_COUNT = 4;
  localparam int LANE_W      = 16;
  localparam int STEP_W      = 4;

  typedef logic [1:0]        idx_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam idx_t LAST_IDX = idx_t'(STATE_COUNT - 1);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_A_ROW0      = 3'd0,
    REG_A_ROW1      = 3'd1,
    REG_A_ROW2      = 3'd2,
    REG_A_ROW3      = 3'd3,
    REG_B_COLUMN    = 3'd4,
    REG_K_ROW       = 3'd5,
    REG_SETPOINT    = 3'd6,
    REG_STEP_SIZE   = 3'd7
  } reg_idx_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NOP,   // no datapath action
    UOP_ERR,   // e = x - setpoint, clear accumulator and flag
    UOP_BK,    // prod = B[row] * K[col]
    UOP_MS,    // mcoef = A[row][col] * 256 - prod
    UOP_ME,    // prod = mcoef * e[col]
    UOP_ACC,   // acc += prod
    UOP_DRND,  // d = round(acc >> 16)
    UOP_DTS,   // prod = d * Ts
    UOP_UPD,   // x[row] = sat(x[row] + round(prod >> 16))
    UOP_OUT    // present result
  } uop_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_COL,   // loop over columns until the last one
    JMP_ROW    // loop over rows until the last one
  } jmp_t;

  typedef struct packed {
    uop_t  op;
    jmp_t  jmp;
    step_t target;
  } uword_t;

  typedef struct packed {
    uop_t op;
    idx_t row;
    idx_t col;
  } ctrl_t;

  localparam step_t STEP_ROW_START = step_t'(1);

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    case (s)
      4'd0:    w = '{op: UOP_ERR,  jmp: JMP_NONE, target: '0};
      4'd1:    w = '{op: UOP_BK,   jmp: JMP_NONE, target: '0};
      4'd2:    w = '{op: UOP_MS,   jmp: JMP_NONE, target: '0};
      4'd3:    w = '{op: UOP_ME,   jmp: JMP_NONE, target: '0};
      4'd4:    w = '{op: UOP_ACC,  jmp: JMP_COL,  target: STEP_ROW_START};
      4'd5:    w = '{op: UOP_DRND, jmp: JMP_NONE, target: '0};
      4'd6:    w = '{op: UOP_DTS,  jmp: JMP_NONE, target: '0};
      4'd7:    w = '{op: UOP_UPD,  jmp: JMP_ROW,  target: STEP_ROW_START};
      4'd8:    w = '{op: UOP_OUT,  jmp: JMP_NONE, target: '0};
      default: w = '{op: UOP_NOP,  jmp: JMP_NONE, target: '0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lqr_closed_loop_state_step.sv
// Top level of the four-state discrete LQR closed-loop state step.
`default_nettype none

// Four-state LQR closed-loop update in signed Q8.8. Each input transfer carries
// a measurement that replaces one element of the kept state x, then the block
// computes x += round(round((A*256 - B*K) * (x - setpoint)) * Ts), saturating
// each element to Q8.8, and returns one selected element plus a flag that is set
// if any element clamped. The result is valid the cycle after the last microcode
// step. The steps run on the single shared 36x18 multiplier: per state row, four
// B*K and four M*e multiplies with their subtract and accumulate steps, then one
// Ts scaling. s_tready is low while an item is in work. The result sits in an
// output register, so a new item is taken while a result waits for m_tready;
// only the final present step waits if the previous result has not been taken.
// Configuration (cfg_wen/cfg_index/cfg_data) must be written only while idle;
// the user is bound to this, the block does not enforce it. The configuration
// registers, the sequencer, the state and m_tvalid reset to zero; the working
// and output data registers do not.
module lqr_closed_loop_state_step #(
  parameter int COEF_WIDTH = 16   // used low bits of each 16-bit lane, 8..16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] measurement, [17:16] state_select,
                                      // [19:18] output_select, [23:20] zero
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] next_value
  output logic             m_tuser,   // [0] saturated
  // configuration write port
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import lqrcl_pkg::*;

  // ---------------- configuration registers ----------------
  logic [63:0] a_row [STATE_COUNT];
  logic [63:0] b_column;
  logic [63:0] k_row;
  logic [63:0] setpoint_vector;
  logic [15:0] step_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < STATE_COUNT; r++) a_row[r] <= '0;
      b_column        <= '0;
      k_row           <= '0;
      setpoint_vector <= '0;
      step_size       <= '0;
    end else if (cfg_wen) begin
      case (reg_idx_t'(cfg_index))
        REG_A_ROW0:    a_row[0]        <= cfg_data;
        REG_A_ROW1:    a_row[1]        <= cfg_data;
        REG_A_ROW2:    a_row[2]        <= cfg_data;
        REG_A_ROW3:    a_row[3]        <= cfg_data;
        REG_B_COLUMN:  b_column        <= cfg_data;
        REG_K_ROW:     k_row           <= cfg_data;
        REG_SETPOINT:  setpoint_vector <= cfg_data;
        REG_STEP_SIZE: step_size       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Pick lane k of a packed word, keep the low COEF_WIDTH bits, sign-extend.
  function automatic logic signed [LANE_W-1:0] lane(logic [63:0] w, idx_t k);
    logic signed [COEF_WIDTH-1:0] t;
    t = w[LANE_W*k +: COEF_WIDTH];
    return LANE_W'(t);
  endfunction

  // ---------------- handshake and sequencer ----------------
  ctrl_t ctrl;
  logic  busy;
  logic  in_xfer;
  logic  stall;

  assign s_tready = !busy;
  assign in_xfer  = s_tvalid && s_tready;
  assign stall    = m_tvalid && !m_tready;   // previous result not yet taken

  lqrcl_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (in_xfer),
    .stall (stall),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // ---------------- datapath ----------------
  logic signed [15:0] state_vec [STATE_COUNT];
  logic signed [16:0] e_vec [STATE_COUNT];   // x - setpoint, Q8.8 in 17 bits
  logic signed [31:0] mcoef;                 // A*256 - B*K, Q.16
  logic signed [51:0] acc;                   // sum M*e, Q.24
  logic signed [35:0] dval;                  // rounded row sum, Q.8
  logic signed [53:0] prod;                  // shared multiplier output register
  idx_t               osel;
  logic signed [15:0] out_val;
  logic               sat;

  logic signed [15:0] a_lane, b_lane, k_lane;
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] mul_p;
  logic signed [31:0] mcoef_next;
  logic signed [35:0] dval_next;
  logic signed [37:0] delta;
  logic signed [37:0] nv_wide;
  logic signed [15:0] nv;
  logic               nv_clamped;

  assign a_lane = lane(a_row[ctrl.row], ctrl.col);
  assign b_lane = lane(b_column, ctrl.row);
  assign k_lane = lane(k_row, ctrl.col);

  // Operand select for the one multiplier.
  always_comb begin
    case (ctrl.op)
      UOP_BK: begin
        mul_a = 36'(b_lane);
        mul_b = 18'(k_lane);
      end
      UOP_ME: begin
        mul_a = 36'(mcoef);
        mul_b = 18'(e_vec[ctrl.col]);
      end
      UOP_DTS: begin
        mul_a = dval;
        mul_b = $signed({2'b00, step_size});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // |B*K| <= 2^30 and |A*256| <= 2^23, so the difference fits 32 bits.
  assign mcoef_next = (32'(a_lane) <<< 8) - prod[31:0];
  assign dval_next  = 36'((acc + 52'sd32768) >>> 16);
  assign delta      = 38'((prod + 54'sd32768) >>> 16);
  assign nv_wide    = 38'(state_vec[ctrl.row]) + delta;

  always_comb begin
    nv_clamped = 1'b0;
    nv         = nv_wide[15:0];
    if (nv_wide > 38'sd32767) begin
      nv         = 16'sh7fff;
      nv_clamped = 1'b1;
    end else if (nv_wide < -38'sd32768) begin
      nv         = -16'sh8000;
      nv_clamped = 1'b1;
    end
  end

  // State vector: measurement write on transfer, row writes during the update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < STATE_COUNT; r++) state_vec[r] <= '0;
    end else if (in_xfer) begin
      state_vec[s_tdata[17:16]] <= $signed(s_tdata[15:0]);
    end else if (ctrl.op == UOP_UPD) begin
      state_vec[ctrl.row] <= nv;
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) osel <= s_tdata[19:18];
    case (ctrl.op)
      UOP_ERR: begin
        for (int r = 0; r < STATE_COUNT; r++)
          e_vec[r] <= 17'(state_vec[r]) - 17'(lane(setpoint_vector, idx_t'(r)));
        acc <= '0;
        sat <= 1'b0;
      end
      UOP_BK, UOP_ME, UOP_DTS: prod <= mul_p;
      UOP_MS:   mcoef <= mcoef_next;
      UOP_ACC:  acc <= acc + 52'(prod);
      UOP_DRND: dval <= dval_next;
      UOP_UPD: begin
        sat <= sat | nv_clamped;
        acc <= '0;
        if (ctrl.row == osel) out_val <= nv;
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  logic present;
  assign present = (ctrl.op == UOP_OUT) && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (present) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (present) begin
      m_tdata <= out_val;
      m_tuser <= sat;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lqrcl_seq.sv
// Microcode sequencer: step counter, row/column loop counters and control word fetch.
`default_nettype none

module lqrcl_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          stall,
  output lqrcl_pkg::ctrl_t   ctrl,
  output logic               busy
);
  import lqrcl_pkg::*;

  step_t  step, step_next;
  idx_t   row, row_next;
  idx_t   col, col_next;
  logic   busy_next;
  uword_t uw;

  assign uw = ucode_rom(step);

  always_comb begin
    step_next = step;
    row_next  = row;
    col_next  = col;
    busy_next = busy;
    if (start) begin
      busy_next = 1'b1;
      step_next = '0;
      row_next  = '0;
      col_next  = '0;
    end else if (busy && !(uw.op == UOP_OUT && stall)) begin
      case (uw.jmp)
        JMP_COL: begin
          if (col != LAST_IDX) begin
            col_next  = col + idx_t'(1);
            step_next = uw.target;
          end else begin
            col_next  = '0;
            step_next = step + step_t'(1);
          end
        end
        JMP_ROW: begin
          if (row != LAST_IDX) begin
            row_next  = row + idx_t'(1);
            step_next = uw.target;
          end else begin
            row_next  = '0;
            step_next = step + step_t'(1);
          end
        end
        default: step_next = step + step_t'(1);
      endcase
      if (uw.op == UOP_OUT) busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      row  <= '0;
      col  <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
      row  <= row_next;
      col  <= col_next;
    end
  end

  always_comb begin
    ctrl.op  = busy ? uw.op : UOP_NOP;
    ctrl.row = row;
    ctrl.col = col;
  end

endmodule

`default_nettype wire

>>> hw/rtl/lqrcl_checker.sv
// Port-level assertions for the LQR state step block, bound to its top level.
`default_nettype none

module lqrcl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tuser
);

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one item at a time: input closes after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after transfer");

  // input closes only because of a transfer
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid))
    else $error("s_tready fell without a transfer");

  // a new result only appears at the end of work on an item
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

endmodule

bind lqr_closed_loop_state_step lqrcl_checker u_chk (.*);

`default_nettype wire
